// ===== design/cigar_run_merge_and_stats_macros.svh =====
// Assertion macros for the CIGAR run merger checker.
`ifndef CIGAR_RUN_MERGE_AND_STATS_MACROS_SVH
`define CIGAR_RUN_MERGE_AND_STATS_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CRMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CRMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/crms_pkg.sv =====
// Types, opcodes and saturating helpers for the CIGAR run merger.
package crms_pkg;

    localparam int LEN_W  = 28;
    localparam int CODE_W = 4;
    localparam int TOT_W  = 32;
    localparam int CHIM_W = 16;

    localparam logic [CODE_W-1:0] OP_M  = 4'd0;
    localparam logic [CODE_W-1:0] OP_I  = 4'd1;
    localparam logic [CODE_W-1:0] OP_D  = 4'd2;
    localparam logic [CODE_W-1:0] OP_N  = 4'd3;
    localparam logic [CODE_W-1:0] OP_S  = 4'd4;
    localparam logic [CODE_W-1:0] OP_EQ = 4'd7;
    localparam logic [CODE_W-1:0] OP_X  = 4'd8;

    localparam int BUF_DEPTH = 4;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic              last;
        logic              empty;
        logic [TOT_W-1:0]  query;
        logic [TOT_W-1:0]  refr;
        logic [TOT_W-1:0]  del;
        logic [TOT_W-1:0]  edit;
        logic [CHIM_W-1:0] chim;
    } t_result;

    // Up to two result words produced by one operation.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    w0;
        t_result    w1;
    } t_push;

    function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {{(TOT_W-LEN_W+1){1'b0}}, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
    endfunction

endpackage

// ===== design/crms_core.sv =====
// Run merge and record statistics: pending op and running totals.
module crms_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic                                i_keep,
    input  logic [crms_pkg::LEN_W-1:0]          i_len,
    input  logic [crms_pkg::CODE_W-1:0]         i_code,
    input  logic                                i_end,
    output crms_pkg::t_push                     o_push
);

    logic                           r_pend_valid;
    logic [crms_pkg::CODE_W-1:0]    r_pend_code;
    logic [crms_pkg::LEN_W-1:0]     r_pend_len;
    logic [crms_pkg::TOT_W-1:0]     r_query, r_refr, r_del, r_edit;
    logic [crms_pkg::CHIM_W-1:0]    r_chim;

    logic                           n_pend_valid;
    logic [crms_pkg::CODE_W-1:0]    n_pend_code;
    logic [crms_pkg::LEN_W-1:0]     n_pend_len;
    logic [crms_pkg::TOT_W-1:0]     n_query, n_refr, n_del, n_edit;
    logic [crms_pkg::CHIM_W-1:0]    n_chim;

    logic                           known;
    logic [crms_pkg::CODE_W-1:0]    cc;
    logic                           merge, drop, flush;
    crms_pkg::t_result              flush_w, fin_w;

    // Totals of a saturating sum equal the saturated raw sum, so the four
    // record statistics are kept directly.
    always_comb begin
        known   = i_code <= crms_pkg::OP_X;
        cc      = (i_code == crms_pkg::OP_X && !i_keep) ? crms_pkg::OP_M : i_code;
        n_query = r_query;
        n_refr  = r_refr;
        n_del   = r_del;
        n_edit  = r_edit;
        n_chim  = r_chim;
        if (known) begin
            if (i_code inside {crms_pkg::OP_S, crms_pkg::OP_M, crms_pkg::OP_I,
                               crms_pkg::OP_EQ, crms_pkg::OP_X}) begin
                n_query = crms_pkg::sat_tot(r_query, i_len);
            end
            if (i_code inside {crms_pkg::OP_M, crms_pkg::OP_D, crms_pkg::OP_N,
                               crms_pkg::OP_EQ, crms_pkg::OP_X}) begin
                n_refr = crms_pkg::sat_tot(r_refr, i_len);
            end
            if (i_code inside {crms_pkg::OP_D, crms_pkg::OP_N}) begin
                n_del = crms_pkg::sat_tot(r_del, i_len);
            end
            if (i_code inside {crms_pkg::OP_X, crms_pkg::OP_I, crms_pkg::OP_D,
                               crms_pkg::OP_N}) begin
                n_edit = crms_pkg::sat_tot(r_edit, i_len);
            end
            if (i_code == crms_pkg::OP_N && i_len == '0 && r_chim != '1) begin
                n_chim = r_chim + 1'b1;
            end
        end

        merge = known && r_pend_valid && cc == r_pend_code &&
                (cc != crms_pkg::OP_N || (i_len != '0 && r_pend_len != '0));
        drop  = !merge && cc != crms_pkg::OP_N && i_len == '0;
        flush = known && !merge && !drop && r_pend_valid;

        n_pend_valid = r_pend_valid;
        n_pend_code  = r_pend_code;
        n_pend_len   = r_pend_len;
        if (known && merge) begin
            n_pend_len = crms_pkg::sat_len(r_pend_len, i_len);
        end else if (known && !drop) begin
            n_pend_valid = 1'b1;
            n_pend_code  = cc;
            n_pend_len   = i_len;
        end

        flush_w       = '0;
        flush_w.len   = r_pend_len;
        flush_w.code  = r_pend_code;

        fin_w         = '0;
        fin_w.last    = 1'b1;
        fin_w.empty   = !n_pend_valid;
        fin_w.len     = n_pend_valid ? n_pend_len : '0;
        fin_w.code    = n_pend_valid ? n_pend_code : '0;
        fin_w.query   = n_query;
        fin_w.refr    = n_refr;
        fin_w.del     = n_del;
        fin_w.edit    = n_edit;
        fin_w.chim    = n_chim;

        o_push.cnt = !i_fire ? 2'd0 : 2'({1'b0, flush} + {1'b0, i_end});
        o_push.w0  = flush ? flush_w : fin_w;
        o_push.w1  = fin_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_end)) begin
            r_pend_valid <= 1'b0;
            r_pend_code  <= '0;
            r_pend_len   <= '0;
            r_query      <= '0;
            r_refr       <= '0;
            r_del        <= '0;
            r_edit       <= '0;
            r_chim       <= '0;
        end else if (i_fire) begin
            r_pend_valid <= n_pend_valid;
            r_pend_code  <= n_pend_code;
            r_pend_len   <= n_pend_len;
            r_query      <= n_query;
            r_refr       <= n_refr;
            r_del        <= n_del;
            r_edit       <= n_edit;
            r_chim       <= n_chim;
        end
    end

endmodule

// ===== design/crms_obuf.sv =====
// Result buffer: takes up to two words a cycle, gives one a cycle while i_stall is low.
module crms_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crms_pkg::t_push     i_push,
    input  logic                i_stall,
    output logic                o_valid,
    output crms_pkg::t_result   o_word,
    output logic                o_room
);

    crms_pkg::t_result              r_mem [crms_pkg::BUF_DEPTH];
    logic [crms_pkg::BUF_AW-1:0]    r_wr, r_rd;
    logic [crms_pkg::BUF_CW-1:0]    r_count;
    logic [crms_pkg::BUF_AW-1:0]    wr_nxt;
    logic                           pop;

    assign wr_nxt  = r_wr + 1'b1;
    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    assign o_room  = r_count <= crms_pkg::BUF_CW'(crms_pkg::BUF_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.w0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_nxt] <= i_push.w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + crms_pkg::BUF_AW'(i_push.cnt);
            r_rd    <= r_rd + crms_pkg::BUF_AW'(pop);
            r_count <= r_count + crms_pkg::BUF_CW'(i_push.cnt)
                     - crms_pkg::BUF_CW'(pop);
        end
    end

endmodule

// ===== design/cigar_run_merge_and_stats.sv =====
// Top level of the CIGAR run merger with per-record statistics.
//
//  channel   direction  handshake                 word
//  input     in         i_valid / o_stall         op length, op code, record end
//  result    out        o_valid / i_stall         merged op, flags, record statistics
//  config    in         i_cfg_valid / o_cfg_ready keep_mismatch_ops bit
//
// One op per cycle while the result buffer has room: input register, merge/statistics logic, result buffer.
// A result becomes visible once the accepted op has left the input register and been written into the result buffer.
// An op that closes one run and ends its record yields two words; the output
// drains one word a cycle while i_stall is low.
// Input stalls when an op waits in the input register and the 4-word result buffer has room for fewer than two words.
// Synchronous active-low reset empties the buffer and clears all record state.
module cigar_run_merge_and_stats (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [crms_pkg::LEN_W-1:0]      i_op_length,
    input  logic [crms_pkg::CODE_W-1:0]     i_op_code,
    input  logic                            i_record_end,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [crms_pkg::LEN_W-1:0]      o_out_length,
    output logic [crms_pkg::CODE_W-1:0]     o_out_code,
    output logic                            o_out_last,
    output logic                            o_out_empty,
    output logic [crms_pkg::TOT_W-1:0]      o_query_length,
    output logic [crms_pkg::TOT_W-1:0]      o_reference_length,
    output logic [crms_pkg::TOT_W-1:0]      o_deletion_count,
    output logic [crms_pkg::TOT_W-1:0]      o_edit_distance,
    output logic [crms_pkg::CHIM_W-1:0]     o_chimera_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_keep_mismatch_ops
);

    logic                           r_keep;
    logic                           r_in_valid;
    logic [crms_pkg::LEN_W-1:0]     r_len;
    logic [crms_pkg::CODE_W-1:0]    r_code;
    logic                           r_end;
    logic                           room, fire, load;
    crms_pkg::t_push                push;
    crms_pkg::t_result              word;

    assign o_cfg_ready = 1'b1;
    assign fire        = r_in_valid && room;
    assign o_stall     = r_in_valid && !room;
    assign load        = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep     <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_keep <= i_cfg_keep_mismatch_ops;
            end
            if (load) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_len  <= i_op_length;
            r_code <= i_op_code;
            r_end  <= i_record_end;
        end
    end

    crms_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_keep  (r_keep),
        .i_len   (r_len),
        .i_code  (r_code),
        .i_end   (r_end),
        .o_push  (push)
    );

    crms_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_word  (word),
        .o_room  (room)
    );

    assign o_out_length       = word.len;
    assign o_out_code         = word.code;
    assign o_out_last         = word.last;
    assign o_out_empty        = word.empty;
    assign o_query_length     = word.query;
    assign o_reference_length = word.refr;
    assign o_deletion_count   = word.del;
    assign o_edit_distance    = word.edit;
    assign o_chimera_count    = word.chim;

endmodule

// ===== design/crms_chk.sv =====
// Port-level checker for the CIGAR run merger, bound to the top level.
`include "cigar_run_merge_and_stats_macros.svh"

module crms_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic [crms_pkg::LEN_W-1:0]      o_out_length,
    input  logic [crms_pkg::CODE_W-1:0]     o_out_code,
    input  logic                            o_out_last,
    input  logic                            o_out_empty,
    input  logic [crms_pkg::TOT_W-1:0]      o_query_length,
    input  logic [crms_pkg::TOT_W-1:0]      o_reference_length,
    input  logic [crms_pkg::TOT_W-1:0]      o_deletion_count,
    input  logic [crms_pkg::TOT_W-1:0]      o_edit_distance,
    input  logic [crms_pkg::CHIM_W-1:0]     o_chimera_count
);

    `CRMS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out_length) && $stable(o_out_code) && $stable(o_out_last), "stalled result word changed")
    `CRMS_ASSERT_NOW(a_empty_marker, o_valid && o_out_empty, o_out_last && o_out_length == '0 && o_out_code == '0, "empty marker malformed")
    `CRMS_ASSERT_NOW(a_mid_stats_zero, o_valid && !o_out_last, o_query_length == '0 && o_reference_length == '0 && o_deletion_count == '0 && o_edit_distance == '0 && o_chimera_count == '0, "statistics on a non-final word")
    `CRMS_ASSERT_NOW(a_del_bound, o_valid && o_out_last, o_reference_length >= o_deletion_count && o_edit_distance >= o_deletion_count, "deletions exceed reference or edit totals")

endmodule

bind cigar_run_merge_and_stats crms_chk u_crms_chk (.*);
